[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i while rst_ni is high.
`define MPU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define MPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/mpu_pkg.sv]
`timescale 1ns / 1ps

package mpu_pkg;

  localparam int FEATURES        = 8;
  localparam int ROW_LEN         = FEATURES + 1;
  localparam int CLASSES         = 4;
  localparam int FEAT_W          = 8;
  localparam int CLASS_W         = 2;
  localparam int NCLS_W          = 3;
  localparam int BEST_W          = 32;
  localparam int WEIGHT_BITS_DEF = 20;

  localparam logic [NCLS_W-1:0] NCLS_RST = 3'd4;

  typedef enum logic {
    CMD_CLASSIFY = 1'b0,
    CMD_TRAIN    = 1'b1
  } cmd_e;

  typedef logic signed [FEAT_W-1:0] feat_t;

  // Row update request from the merge side to the lanes
  typedef struct packed {
    logic               en;
    logic [CLASS_W-1:0] pred;
    logic [CLASS_W-1:0] label;
  } upd_t;

  typedef struct packed {
    logic [CLASS_W-1:0]       pred;
    logic                     miss;
    logic                     lerr;
    logic signed [BEST_W-1:0] best_score;
  } res_t;

endpackage

[design/mpu_if.sv]
`timescale 1ns / 1ps

interface mpu_in_if;
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  mpu_pkg::feat_t        feature_0;
  mpu_pkg::feat_t        feature_1;
  mpu_pkg::feat_t        feature_2;
  mpu_pkg::feat_t        feature_3;
  mpu_pkg::feat_t        feature_4;
  mpu_pkg::feat_t        feature_5;
  mpu_pkg::feat_t        feature_6;
  mpu_pkg::feat_t        feature_7;
  logic [1:0]            true_label;

  modport source (
    output valid, cmd, feature_0, feature_1, feature_2, feature_3,
           feature_4, feature_5, feature_6, feature_7, true_label,
    input  ready
  );
  modport sink (
    input  valid, cmd, feature_0, feature_1, feature_2, feature_3,
           feature_4, feature_5, feature_6, feature_7, true_label,
    output ready
  );
endinterface

interface mpu_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         predicted_class;
  logic               mispredicted;
  logic               label_error;
  logic signed [31:0] best_score;

  modport source (
    output valid, predicted_class, mispredicted, label_error, best_score,
    input  ready
  );
  modport sink (
    input  valid, predicted_class, mispredicted, label_error, best_score,
    output ready
  );
endinterface

interface mpu_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[design/mpu_lane.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpu_lane #(
  parameter int WEIGHT_BITS = mpu_pkg::WEIGHT_BITS_DEF,
  parameter int LANE        = 0,
  localparam int SCORE_W    = WEIGHT_BITS + mpu_pkg::FEAT_W + $clog2(mpu_pkg::ROW_LEN)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  mpu_pkg::feat_t            x_i [mpu_pkg::ROW_LEN],
  input  mpu_pkg::feat_t            upd_x_i [mpu_pkg::ROW_LEN],
  input  mpu_pkg::upd_t             upd_i,
  output logic signed [SCORE_W-1:0] score_o
);
  import mpu_pkg::*;

  localparam int PROD_W = WEIGHT_BITS + FEAT_W;
  localparam int WS     = WEIGHT_BITS + 1;

  logic signed [WEIGHT_BITS-1:0] w_q [ROW_LEN];
  logic signed [WEIGHT_BITS-1:0] w_d [ROW_LEN];
  logic signed [SCORE_W-1:0]     score_d;
  logic signed [SCORE_W-1:0]     score_q;
  logic                          add_hit;
  logic                          sub_hit;

  // Dot product of this class row with the incoming vector
  always_comb begin : dot
    logic signed [PROD_W-1:0] prod;
    score_d = '0;
    for (int i = 0; i < ROW_LEN; i++) begin
      prod    = w_q[i] * x_i[i];
      score_d = score_d + SCORE_W'(prod);
    end
  end

  assign add_hit = upd_i.en && (upd_i.label == CLASS_W'(LANE));
  assign sub_hit = upd_i.en && (upd_i.pred == CLASS_W'(LANE));

  // Add or subtract the held vector, saturate each weight
  always_comb begin : wupd
    logic signed [WS-1:0] dx;
    logic signed [WS-1:0] sum;
    for (int i = 0; i < ROW_LEN; i++) begin
      dx  = WS'(upd_x_i[i]);
      sum = sub_hit ? (WS'(w_q[i]) - dx) : (WS'(w_q[i]) + dx);
      if (sum[WEIGHT_BITS] != sum[WEIGHT_BITS-1]) begin
        w_d[i] = {sum[WEIGHT_BITS], {(WEIGHT_BITS-1){~sum[WEIGHT_BITS]}}};
      end else begin
        w_d[i] = sum[WEIGHT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROW_LEN; i++) begin
        w_q[i] <= '0;
      end
    end else if (add_hit || sub_hit) begin
      w_q <= w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      score_q <= score_d;
    end
  end

  assign score_o = score_q;

  `MPU_ASSERT(a_one_row_op, !(add_hit && sub_hit))

endmodule

[design/mpu_merge.sv]
`timescale 1ns / 1ps

module mpu_merge #(
  parameter int WEIGHT_BITS = mpu_pkg::WEIGHT_BITS_DEF,
  localparam int SCORE_W    = WEIGHT_BITS + mpu_pkg::FEAT_W + $clog2(mpu_pkg::ROW_LEN)
) (
  input  logic signed [SCORE_W-1:0]       score_i [mpu_pkg::CLASSES],
  input  logic [mpu_pkg::NCLS_W-1:0]      n_active_i,
  input  logic                            train_i,
  input  logic [mpu_pkg::CLASS_W-1:0]     label_i,
  output mpu_pkg::res_t                   res_o
);
  import mpu_pkg::*;

  logic signed [SCORE_W-1:0] best;
  logic [CLASS_W-1:0]        best_idx;
  logic signed [BEST_W-1:0]  sat;

  // Strict compare keeps the lowest index on a tie
  always_comb begin
    best     = score_i[0];
    best_idx = '0;
    for (int c = 1; c < CLASSES; c++) begin
      if ((NCLS_W'(c) < n_active_i) && (score_i[c] > best)) begin
        best     = score_i[c];
        best_idx = CLASS_W'(c);
      end
    end
  end

  generate
    if (SCORE_W > BEST_W) begin : g_sat
      always_comb begin
        if (best[SCORE_W-1:BEST_W-1] == {(SCORE_W-BEST_W+1){best[SCORE_W-1]}}) begin
          sat = best[BEST_W-1:0];
        end else begin
          sat = {best[SCORE_W-1], {(BEST_W-1){~best[SCORE_W-1]}}};
        end
      end
    end else begin : g_ext
      assign sat = BEST_W'(best);
    end
  endgenerate

  always_comb begin
    res_o.pred       = best_idx;
    res_o.miss       = train_i && (best_idx != label_i);
    res_o.lerr       = train_i && (NCLS_W'(label_i) >= n_active_i);
    res_o.best_score = sat;
  end

endmodule

[design/multiclass_perceptron_update_unit.sv]
// Online multiclass perceptron. Each transaction carries eight signed 8-bit
// features (a bias input of 1 is placed in front), a true label and a command
// (classify, or classify and train on a miss). One lane per class holds that
// class's weight row in flip-flops and forms its score in the cycle the
// transaction is accepted; once the result register is free or being read,
// the merge picks the lowest-indexed top score among the active classes,
// writes the result register and, on a training miss with a valid label,
// moves both affected rows with saturation. A new item is accepted only
// after the current one has written its result: the next item's scores must
// see the rows this item writes back. The result register lets the next item
// enter while a result waits. Weights clear to zero at reset; num_classes
// resets to 4, with 0 treated as 1 and values above 4 treated as 4. Write
// num_classes only while no transaction is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multiclass_perceptron_update_unit #(
  parameter int WEIGHT_BITS = mpu_pkg::WEIGHT_BITS_DEF,
  localparam int SCORE_W    = WEIGHT_BITS + mpu_pkg::FEAT_W + $clog2(mpu_pkg::ROW_LEN)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mpu_in_if.sink    in_i,
  mpu_out_if.source out_o,
  mpu_cfg_if.sink   cfg_i
);
  import mpu_pkg::*;

  logic [NCLS_W-1:0]         ncls_q;
  logic [NCLS_W-1:0]         n_active;
  feat_t                     x_in [ROW_LEN];
  feat_t                     x_q [ROW_LEN];
  logic                      s1_valid_q;
  cmd_e                      cmd_q;
  logic [CLASS_W-1:0]        label_q;
  logic signed [SCORE_W-1:0] score [CLASSES];
  logic                      in_acc;
  logic                      fire;
  res_t                      res;
  res_t                      out_q;
  logic                      out_valid_q;
  upd_t                      upd;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncls_q <= NCLS_RST;
    end else if (cfg_i.valid) begin
      ncls_q <= cfg_i.data;
    end
  end

  always_comb begin
    if (ncls_q == '0) begin
      n_active = NCLS_W'(1);
    end else if (ncls_q > NCLS_W'(CLASSES)) begin
      n_active = NCLS_W'(CLASSES);
    end else begin
      n_active = ncls_q;
    end
  end

  // Augmented vector, bias first
  assign x_in[0] = feat_t'(1);
  assign x_in[1] = in_i.feature_0;
  assign x_in[2] = in_i.feature_1;
  assign x_in[3] = in_i.feature_2;
  assign x_in[4] = in_i.feature_3;
  assign x_in[5] = in_i.feature_4;
  assign x_in[6] = in_i.feature_5;
  assign x_in[7] = in_i.feature_6;
  assign x_in[8] = in_i.feature_7;

  // Hold off the next transaction until the rows of this one are written
  assign in_i.ready = !s1_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign fire       = s1_valid_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q     <= x_in;
      cmd_q   <= cmd_e'(in_i.cmd);
      label_q <= in_i.true_label;
    end
  end

  generate
    for (genvar c = 0; c < CLASSES; c++) begin : g_lane
      mpu_lane #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .LANE        (c)
      ) u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .load_i  (in_acc),
        .x_i     (x_in),
        .upd_x_i (x_q),
        .upd_i   (upd),
        .score_o (score[c])
      );
    end
  endgenerate

  mpu_merge #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_merge (
    .score_i    (score),
    .n_active_i (n_active),
    .train_i    (cmd_q == CMD_TRAIN),
    .label_i    (label_q),
    .res_o      (res)
  );

  always_comb begin
    upd.en    = fire && res.miss && !res.lerr;
    upd.pred  = res.pred;
    upd.label = label_q;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.predicted_class = out_q.pred;
  assign out_o.mispredicted    = out_q.miss;
  assign out_o.label_error     = out_q.lerr;
  assign out_o.best_score      = out_q.best_score;

  `MPU_ASSERT(a_upd_train, upd.en |-> (fire && (cmd_q == CMD_TRAIN)))
  `MPU_ASSERT(a_pred_active, fire |-> (NCLS_W'(res.pred) < n_active))
  `MPU_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_i.ready)

endmodule

[bench/multiclass_perceptron_update_unit_tb.sv]
`timescale 1ns / 1ps

module multiclass_perceptron_update_unit_tb;
  import mpu_pkg::*;

  localparam int WB          = WEIGHT_BITS_DEF;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    cmd_e               cmd;
    feat_t              feat [FEATURES];
    logic [CLASS_W-1:0] label;
  } sample_t;

  logic clk;
  logic rst_n;

  mpu_in_if  in_if ();
  mpu_out_if out_if ();
  mpu_cfg_if cfg_if ();

  multiclass_perceptron_update_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the weight rows and the class count register
  logic signed [WB-1:0] row_w [CLASSES][ROW_LEN];
  logic [NCLS_W-1:0]    class_count;
  feat_t                proto [CLASSES][FEATURES];

  res_t        verdict_q [$];
  int          mismatches;
  int unsigned cycle_count;
  bit          tx_idle;
  bit          rx_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int effective_classes();
    if (class_count == 0) return 1;
    if (class_count > CLASSES) return CLASSES;
    return int'(class_count);
  endfunction

  function automatic longint clamp_weight(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (WB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Score the active rows, pick the lowest-indexed top score, learn on a miss
  function automatic res_t classify_and_train(sample_t s);
    longint x [ROW_LEN];
    longint score;
    longint best_sc;
    int     n;
    int     best;
    logic   train;
    logic   miss;
    logic   lerr;
    res_t   r;
    n = effective_classes();
    x[0] = 1;
    for (int i = 0; i < FEATURES; i++) x[i + 1] = longint'(s.feat[i]);
    best = 0;
    best_sc = 0;
    for (int c = 0; c < n; c++) begin
      score = 0;
      for (int i = 0; i < ROW_LEN; i++) score += longint'(row_w[c][i]) * x[i];
      if (c == 0 || score > best_sc) begin
        best_sc = score;
        best = c;
      end
    end
    train = (s.cmd == CMD_TRAIN);
    miss = train && (best != int'(s.label));
    lerr = train && (int'(s.label) >= n);
    if (miss && !lerr) begin
      for (int i = 0; i < ROW_LEN; i++) begin
        row_w[best][i]    = WB'(clamp_weight(longint'(row_w[best][i]) - x[i]));
        row_w[s.label][i] = WB'(clamp_weight(longint'(row_w[s.label][i]) + x[i]));
      end
    end
    if (best_sc > longint'(32'sh7fffffff)) best_sc = longint'(32'sh7fffffff);
    if (best_sc < -longint'(32'sh7fffffff) - 1) best_sc = -longint'(32'sh7fffffff) - 1;
    r.pred = CLASS_W'(best);
    r.miss = miss;
    r.lerr = lerr;
    r.best_score = BEST_W'(best_sc);
    return r;
  endfunction

  function automatic sample_t uniform_sample(cmd_e c, int v, logic [CLASS_W-1:0] lbl);
    sample_t s;
    s.cmd = c;
    s.label = lbl;
    for (int i = 0; i < FEATURES; i++) s.feat[i] = feat_t'(v);
    return s;
  endfunction

  // Mostly noisy copies of a per-class prototype so the rows actually learn
  function automatic sample_t draw_sample(int n);
    sample_t s;
    int      kind;
    int      v;
    kind = $urandom_range(0, 9);
    s.cmd = ($urandom_range(0, 3) == 0) ? CMD_CLASSIFY : CMD_TRAIN;
    if ($urandom_range(0, 7) == 0) s.label = CLASS_W'($urandom_range(0, 3));
    else s.label = CLASS_W'($urandom_range(0, n - 1));
    for (int i = 0; i < FEATURES; i++) begin
      if (kind == 0) begin
        s.feat[i] = ($urandom_range(0, 1) == 1) ? feat_t'(127) : feat_t'(-128);
      end else if (kind == 1) begin
        s.feat[i] = feat_t'($urandom);
      end else begin
        v = int'(proto[s.label][i]) + int'($urandom_range(0, 48)) - 24;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        s.feat[i] = feat_t'(v);
      end
    end
    return s;
  endfunction

  task automatic present_sample(sample_t s);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid      = 1'b1;
    in_if.cmd        = s.cmd;
    in_if.feature_0  = s.feat[0];
    in_if.feature_1  = s.feat[1];
    in_if.feature_2  = s.feat[2];
    in_if.feature_3  = s.feat[3];
    in_if.feature_4  = s.feat[4];
    in_if.feature_5  = s.feat[5];
    in_if.feature_6  = s.feat[6];
    in_if.feature_7  = s.feat[7];
    in_if.true_label = s.label;
    do @(posedge clk); while (!in_if.ready);
    verdict_q.push_back(classify_and_train(s));
  endtask

  // Drop valid and hold until every verdict has come back
  task automatic settle_block();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_class_count(logic [NCLS_W-1:0] v);
    settle_block();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data  = v;
    do @(posedge clk); while (!cfg_if.ready);
    class_count = v;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic void check_field(string fld, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
      mismatches++;
    end
  endfunction

  initial begin : result_monitor
    int   stall;
    res_t want;
    @(posedge rst_n);
    forever begin
      stall = rx_idle ? $urandom_range(0, 7) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_if.ready = 1'b0;
      end
      @(negedge clk);
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual class %0d score %0d",
                 $time, out_if.predicted_class, out_if.best_score);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("predicted_class", want.pred, out_if.predicted_class);
        check_field("mispredicted", want.miss, out_if.mispredicted);
        check_field("label_error", want.lerr, out_if.label_error);
        check_field("best_score", want.best_score, out_if.best_score);
      end
    end
  end

  // Zero rows at first: ties, bias-only samples, first misses
  task automatic test_zero_weights();
    sample_t s;
    present_sample(uniform_sample(CMD_CLASSIFY, 127, 0));
    present_sample(uniform_sample(CMD_TRAIN, -128, 0));
    present_sample(uniform_sample(CMD_TRAIN, 127, 3));
    present_sample(uniform_sample(CMD_CLASSIFY, 127, 1));
    present_sample(uniform_sample(CMD_CLASSIFY, -128, 2));
    s = uniform_sample(CMD_TRAIN, 127, 2);
    for (int i = 1; i < FEATURES; i += 2) s.feat[i] = feat_t'(-128);
    present_sample(s);
    present_sample(uniform_sample(CMD_TRAIN, 0, 1));
    present_sample(uniform_sample(CMD_TRAIN, 0, 1));
  endtask

  // Count of zero acts as one, above four as four; labels past the count flag
  task automatic test_class_count();
    set_class_count(0);
    present_sample(uniform_sample(CMD_TRAIN, 127, 0));
    present_sample(uniform_sample(CMD_TRAIN, -128, 1));
    present_sample(uniform_sample(CMD_TRAIN, 0, 3));
    present_sample(uniform_sample(CMD_CLASSIFY, 127, 3));
    set_class_count(7);
    present_sample(uniform_sample(CMD_TRAIN, 127, 3));
    present_sample(uniform_sample(CMD_TRAIN, -128, 2));
    set_class_count(5);
    present_sample(uniform_sample(CMD_CLASSIFY, 127, 1));
    set_class_count(1);
    present_sample(uniform_sample(CMD_TRAIN, 127, 1));
    set_class_count(2);
    present_sample(uniform_sample(CMD_TRAIN, 127, 2));
    present_sample(uniform_sample(CMD_TRAIN, -128, 1));
    present_sample(uniform_sample(CMD_TRAIN, 127, 0));
    set_class_count(3);
    present_sample(uniform_sample(CMD_TRAIN, 127, 3));
    present_sample(uniform_sample(CMD_TRAIN, 5, 2));
    set_class_count(4);
    present_sample(uniform_sample(CMD_TRAIN, -128, 3));
  endtask

  task automatic test_random_training();
    logic [NCLS_W-1:0] counts [8];
    counts = '{3'd4, 3'd2, 3'd7, 3'd3, 3'd0, 3'd1, 3'd5, 3'd4};
    foreach (proto[c, i]) proto[c][i] = feat_t'($urandom);
    for (int p = 0; p < 8; p++) begin
      set_class_count(counts[p]);
      tx_idle = ((p & 1) == 0);
      rx_idle = ((p & 2) == 0);
      for (int k = 0; k < 88; k++) begin
        present_sample(draw_sample(effective_classes()));
        if ($urandom_range(0, 15) == 0) settle_block();
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_CLASSIFY;
    in_if.feature_0  = '0;
    in_if.feature_1  = '0;
    in_if.feature_2  = '0;
    in_if.feature_3  = '0;
    in_if.feature_4  = '0;
    in_if.feature_5  = '0;
    in_if.feature_6  = '0;
    in_if.feature_7  = '0;
    in_if.true_label = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    foreach (row_w[c, i]) row_w[c][i] = '0;
    class_count = NCLS_RST;
    mismatches  = 0;
    cycle_count = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    rst_n       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_zero_weights();
    test_class_count();
    test_random_training();

    settle_block();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/mpu_pkg.sv
design/mpu_if.sv
design/mpu_lane.sv
design/mpu_merge.sv
design/multiclass_perceptron_update_unit.sv
bench/multiclass_perceptron_update_unit_tb.sv
